// ===== rtl/gmcw_pkg.sv =====
// shared types and widths for the grid mask centroid window block
// no dependencies; imported by the top level and its checker
`default_nettype none

package gmcw_pkg;

    localparam int MASK_W  = 12;
    localparam int FIELD_W = 8;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [FIELD_W-1:0] field_t;

endpackage

`default_nettype wire

// ===== rtl/grid_mask_centroid_window.sv =====
// centroid of a covered-cell mask and the clamped window around it
// deep pipeline: row lanes, totals, dividend/divisor, one quotient bit per stage, offsets
// depends on gmcw_pkg
//
//   channel  | signals                                                     | dir
//   ---------+-------------------------------------------------------------+----
//   mask     | mask_valid, mask_ready, covered_mask                        | in
//   result   | result_valid, result_ready, position_height/width, window_* | out
//
// one word accepted per cycle while the result side does not stall;
// the restoring divider resolves one quotient bit per stage.
// reset clears the stage valid bits only; payload registers are not reset.
// a stall at the result side holds only the stages that are full; empty stages
// further up keep accepting, so mask_ready is high whenever result_ready is high.
`default_nettype none

module grid_mask_centroid_window #(
    parameter int SENSOR_SIZE = 160,
    parameter int GRID_ROWS   = 3,
    parameter int GRID_COLS   = 4,
    parameter int WINDOW_SIZE = 16,
    parameter int WIDTH_ALIGN = 8
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 mask_valid,
    output logic                mask_ready,
    input  gmcw_pkg::mask_t     covered_mask,
    output logic                result_valid,
    input  wire                 result_ready,
    output gmcw_pkg::field_t    position_height,
    output gmcw_pkg::field_t    position_width,
    output gmcw_pkg::field_t    window_top,
    output gmcw_pkg::field_t    window_left
);

    import gmcw_pkg::*;

    localparam int NCELL  = GRID_ROWS * GRID_COLS;
    localparam int CELLS  = (NCELL < MASK_W) ? NCELL : MASK_W;
    localparam int MAXRC  = (GRID_ROWS > GRID_COLS) ? GRID_ROWS : GRID_COLS;
    localparam int CW     = $clog2(CELLS + 1);
    localparam int SW_RAW = $clog2((MAXRC - 1) * CELLS + 1);
    localparam int SW     = (SW_RAW < 1) ? 1 : SW_RAW;
    localparam int NW     = $clog2((2 * MAXRC - 1) * CELLS * SENSOR_SIZE + 1);
    localparam int DW     = $clog2(2 * MAXRC * CELLS * WIDTH_ALIGN + 1);
    localparam int QW     = $clog2(SENSOR_SIZE);
    localparam int XW     = (DW + QW > NW) ? DW + QW : NW;
    localparam int OW     = (QW + 1 > FIELD_W) ? QW + 1 : FIELD_W;
    localparam int HALF   = WINDOW_SIZE / 2;
    localparam int NST    = QW + 4;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_F   = NST - 1;

    typedef struct packed {
        logic [NW-1:0] rem_h;
        logic [NW-1:0] rem_w;
        logic [DW-1:0] den_h;
        logic [DW-1:0] den_w;
        logic [QW-1:0] q_h;
        logic [QW-1:0] q_w;
    } div_t;

    function automatic logic [OW-1:0] win_off(input logic [OW-1:0] p);
        logic [OW-1:0] r;
        if (p < OW'(HALF))
        begin
            r = '0;
        end
        else if (p > OW'(SENSOR_SIZE - HALF))
        begin
            r = OW'(SENSOR_SIZE - HALF);
        end
        else
        begin
            r = p - OW'(HALF);
        end
        return r;
    endfunction

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST:0]   adv;

    logic [NCELL+MASK_W-1:0] cells_ext;

    logic [CW-1:0] rcnt_reg [GRID_ROWS];
    logic [CW-1:0] rcnt_next [GRID_ROWS];
    logic [SW-1:0] rcol_reg [GRID_ROWS];
    logic [SW-1:0] rcol_next [GRID_ROWS];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] rowsum_reg;
    logic [SW-1:0] rowsum_next;
    logic [SW-1:0] colsum_reg;
    logic [SW-1:0] colsum_next;

    div_t dv_reg [QW+1];
    div_t dv_next [QW+1];

    logic [OW-1:0] pw_full;
    logic [OW-1:0] ph_full;
    logic [OW-1:0] wt_full;
    logic [OW-1:0] wl_full;

    field_t ph_reg, ph_next;
    field_t pw_reg, pw_next;
    field_t wt_reg, wt_next;
    field_t wl_reg, wl_next;

    // ready chain: a stage takes a word when it is empty or it moves on
    always_comb
    begin
        adv[NST] = result_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? mask_valid : v_reg[0];
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    assign mask_ready = adv[0];
    assign cells_ext  = {{NCELL{1'b0}}, covered_mask};

    // row lanes
    always_comb
    begin
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            rcnt_next[r] = '0;
            rcol_next[r] = '0;
            for (int c = 0; c < GRID_COLS; c++)
            begin
                if (cells_ext[r*GRID_COLS+c])
                begin
                    rcnt_next[r] = rcnt_next[r] + CW'(1);
                    rcol_next[r] = rcol_next[r] + SW'(c);
                end
            end
        end
    end

    // totals
    always_comb
    begin
        count_next  = '0;
        rowsum_next = '0;
        colsum_next = '0;
        for (int r = 0; r < GRID_ROWS; r++)
        begin
            count_next  = count_next + rcnt_reg[r];
            rowsum_next = rowsum_next + SW'(r) * SW'(rcnt_reg[r]);
            colsum_next = colsum_next + rcol_reg[r];
        end
    end

    // dividend and divisor, width divisor folds in the alignment;
    // then the restoring divider, one quotient bit per stage
    always_comb
    begin
        logic [XW-1:0] sh_h;
        logic [XW-1:0] sh_w;
        dv_next[0].rem_h = NW'(SENSOR_SIZE) * (NW'(rowsum_reg) * NW'(2) + NW'(count_reg));
        dv_next[0].rem_w = NW'(SENSOR_SIZE) * (NW'(colsum_reg) * NW'(2) + NW'(count_reg));
        if (count_reg == '0)
        begin
            dv_next[0].den_h = DW'(1);
            dv_next[0].den_w = DW'(1);
        end
        else
        begin
            dv_next[0].den_h = DW'(2 * GRID_ROWS) * DW'(count_reg);
            dv_next[0].den_w = DW'(2 * GRID_COLS * WIDTH_ALIGN) * DW'(count_reg);
        end
        dv_next[0].q_h = '0;
        dv_next[0].q_w = '0;
        for (int k = 0; k < QW; k++)
        begin
            dv_next[k+1] = dv_reg[k];
            sh_h = XW'(dv_reg[k].den_h) << (QW - 1 - k);
            sh_w = XW'(dv_reg[k].den_w) << (QW - 1 - k);
            if (XW'(dv_reg[k].rem_h) >= sh_h)
            begin
                dv_next[k+1].rem_h = NW'(XW'(dv_reg[k].rem_h) - sh_h);
                dv_next[k+1].q_h   = dv_reg[k].q_h | (QW'(1) << (QW - 1 - k));
            end
            if (XW'(dv_reg[k].rem_w) >= sh_w)
            begin
                dv_next[k+1].rem_w = NW'(XW'(dv_reg[k].rem_w) - sh_w);
                dv_next[k+1].q_w   = dv_reg[k].q_w | (QW'(1) << (QW - 1 - k));
            end
        end
    end

    // alignment and window offsets
    always_comb
    begin
        ph_full = OW'(dv_reg[QW].q_h);
        pw_full = OW'(dv_reg[QW].q_w) * OW'(WIDTH_ALIGN);
        wt_full = win_off(ph_full);
        wl_full = win_off(pw_full);
        ph_next = ph_full[FIELD_W-1:0];
        pw_next = pw_full[FIELD_W-1:0];
        wt_next = wt_full[FIELD_W-1:0];
        wl_next = wl_full[FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rcnt_reg <= rcnt_next;
            rcol_reg <= rcol_next;
        end
        if (adv[ST_B])
        begin
            count_reg  <= count_next;
            rowsum_reg <= rowsum_next;
            colsum_reg <= colsum_next;
        end
        for (int k = 0; k <= QW; k++)
        begin
            if (adv[ST_C+k])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (adv[ST_F])
        begin
            ph_reg <= ph_next;
            pw_reg <= pw_next;
            wt_reg <= wt_next;
            wl_reg <= wl_next;
        end
    end

    assign result_valid    = v_reg[ST_F];
    assign position_height = ph_reg;
    assign position_width  = pw_reg;
    assign window_top      = wt_reg;
    assign window_left     = wl_reg;

endmodule

`default_nettype wire

// ===== rtl/gmcw_checker.sv =====
// port-level checks for grid_mask_centroid_window, bound to the top level
// depends on gmcw_pkg
`default_nettype none

module gmcw_checker #(
    parameter int SENSOR_SIZE = 160,
    parameter int WINDOW_SIZE = 16
) (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 mask_valid,
    input wire                 mask_ready,
    input gmcw_pkg::mask_t     covered_mask,
    input wire                 result_valid,
    input wire                 result_ready,
    input gmcw_pkg::field_t    position_height,
    input gmcw_pkg::field_t    position_width,
    input gmcw_pkg::field_t    window_top,
    input gmcw_pkg::field_t    window_left
);

    import gmcw_pkg::*;

    localparam int  HALF   = WINDOW_SIZE / 2;
    localparam bit  FITS_8 = (SENSOR_SIZE <= 256);

    // a waiting mask word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        mask_valid && !mask_ready |=> mask_valid && $stable(covered_mask))
        else $error("waiting mask word changed");

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(position_height) && $stable(position_width)
            && $stable(window_top) && $stable(window_left))
        else $error("stalled result word changed");

    // no bubble backpressure: a free output frees the input
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> mask_ready)
        else $error("input stalled while output is ready");

    // zero position gives zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        FITS_8 && result_valid && position_height == '0 |-> window_top == '0)
        else $error("window_top nonzero for zero position");

    // unclamped window sits half a window before the position
    assert property (@(posedge clk) disable iff (!rst_n)
        FITS_8 && result_valid && position_width >= field_t'(HALF)
        && position_width <= field_t'(SENSOR_SIZE - HALF)
        |-> window_left == position_width - field_t'(HALF))
        else $error("window_left does not track position_width");

endmodule

bind grid_mask_centroid_window gmcw_checker #(
    .SENSOR_SIZE(SENSOR_SIZE),
    .WINDOW_SIZE(WINDOW_SIZE)
) u_gmcw_checker (
    .clk(clk),
    .rst_n(rst_n),
    .mask_valid(mask_valid),
    .mask_ready(mask_ready),
    .covered_mask(covered_mask),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .position_height(position_height),
    .position_width(position_width),
    .window_top(window_top),
    .window_left(window_left)
);

`default_nettype wire
